FILE: rtl/core/digit_trie_prefix_match_core_assert.svh
// Assertion macros for the digit trie prefix match core.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef DIGIT_TRIE_PREFIX_MATCH_CORE_ASSERT_SVH
`define DIGIT_TRIE_PREFIX_MATCH_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Implication checked at every clock edge outside reset.
`define DT_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Implication checked in the cycle after the trigger.
`define DT_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define DT_ASSERT_IMP(label, clk, rst_n, a, c)
`define DT_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: rtl/core/dtpm_pkg.sv
// Shared types and constants for the digit trie prefix match core.
// No dependencies.
package dtpm_pkg;

    // Key actions. Action three leaves the trie alone and reports not found.
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_EXACT  = 2'd1;
    localparam logic [1:0] ACT_PREFIX = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam int FANOUT = 10;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_READ,
        S_EXEC,
        S_OUT
    } be_state_t;

endpackage

FILE: rtl/core/digit_trie_prefix_match_core.sv
// Top level of the digit trie prefix match core.
// Depends on dtpm_pkg, dtpm_front, dtpm_back and dtpm_ram.
//
// One key digit per request enters a two-entry queue; the back end walks a ten-way
// trie held in two single-port node memories (child links and value slots) with a
// registered read. A digit passes through accept, read, execute and retire, and
// whenever a new node is taken its ten entries are first cleared, one per cycle.
// The memory read latency on each child link sets the per-digit time. One result
// appears per key, on its last digit, and waits in an output register.
module digit_trie_prefix_match_core #(
    parameter int NODES = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic [3:0]  digit,
    input  logic        last_digit,
    input  logic [31:0] value,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [31:0] match_value,
    output logic [10:0] nodes_allocated
);

    logic                  q_valid, q_take, q_last;
    logic [1:0]            q_action;
    logic [3:0]            q_digit;
    logic [VALUE_BITS-1:0] q_value;

    dtpm_front #(.VALUE_BITS(VALUE_BITS), .DEPTH(2)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .action(action),
        .digit(digit), .last_digit(last_digit), .value(value), .q_valid(q_valid),
        .q_take(q_take), .q_action(q_action), .q_digit(q_digit), .q_last(q_last),
        .q_value(q_value));

    dtpm_back #(.NODES(NODES), .VALUE_BITS(VALUE_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take),
        .q_action(q_action), .q_digit(q_digit), .q_last(q_last), .q_value(q_value),
        .empty(empty), .pop(pop), .status(status), .match_value(match_value),
        .nodes_allocated(nodes_allocated));

endmodule

FILE: rtl/core/dtpm_ram.sv
// Generic single-port RAM with a registered read.
// No dependencies.
module dtpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write when enabled; the read is registered and returns the old data during a write.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/dtpm_front.sv
// Front end: folds digits and queues requests for the back end.
// No dependencies.
module dtpm_front #(
    parameter int VALUE_BITS = 32,
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            action,
    input  logic [3:0]            digit,
    input  logic                  last_digit,
    input  logic [31:0]           value,
    output logic                  q_valid,
    input  logic                  q_take,
    output logic [1:0]            q_action,
    output logic [3:0]            q_digit,
    output logic                  q_last,
    output logic [VALUE_BITS-1:0] q_value
);

    localparam int W = 2 + 4 + 1 + VALUE_BITS;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  buf_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic [3:0]    fold;
    logic [VALUE_BITS-1:0] vin;
    logic          wr;
    logic [W-1:0]  head;

    // Fold digits above nine and fit the value to the stored width.
    always_comb
    begin
        fold = (digit >= 4'd10) ? (digit - 4'd10) : digit;
        vin = '0;
        if (VALUE_BITS >= 32)
        begin
            vin[31:0] = value;
        end
        else
        begin
            vin = value[VALUE_BITS-1:0];
        end
    end

    assign full = (cnt_reg == (AW+1)'(DEPTH));
    assign wr = push && !full;
    assign q_valid = (cnt_reg != '0);
    assign head = buf_reg[rp_reg];
    assign {q_action, q_digit, q_last, q_value} = head;

    // Request queue storage.
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            buf_reg[wp_reg] <= {action, fold, last_digit, vin};
        end
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (q_take && q_valid)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(q_take && q_valid);
        end
    end

endmodule

FILE: rtl/core/dtpm_back.sv
// Back end: walks the trie in the node memories and builds results.
// Depends on dtpm_pkg, dtpm_ram and the assertion header.
`include "digit_trie_prefix_match_core_assert.svh"
module dtpm_back #(
    parameter int NODES = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_take,
    input  logic [1:0]            q_action,
    input  logic [3:0]            q_digit,
    input  logic                  q_last,
    input  logic [VALUE_BITS-1:0] q_value,
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            status,
    output logic [31:0]           match_value,
    output logic [10:0]           nodes_allocated
);

    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW = $clog2(NODES + 1);
    localparam int ENT = NODES * dtpm_pkg::FANOUT;
    localparam int AW = $clog2(ENT);

    dtpm_pkg::be_state_t state_reg, state_next;
    logic [NW-1:0] walk_reg, walk_next, root_reg, root_next, new_reg, new_next;
    logic          root_valid_reg, root_valid_next;
    logic [LW-1:0] free_reg, free_next;
    logic [10:0]   alloc_reg, alloc_next;
    logic          open_reg, open_next, ended_reg, ended_next, failed_reg, failed_next;
    logic [1:0]    act_reg, act_next;
    logic          best_full_reg, best_full_next;
    logic [VALUE_BITS-1:0] best_reg, best_next;
    logic [3:0]    clr_reg, clr_next;
    logic          link_clr_reg, link_clr_next;
    logic          res_valid_reg, res_valid_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [31:0]   res_value_reg, res_value_next;
    logic [10:0]   res_alloc_reg, res_alloc_next;

    logic          we;
    logic [AW-1:0] addr;
    logic [LW-1:0]         c_wdata, c_rdata;
    logic [VALUE_BITS:0]   s_wdata, s_rdata;
    logic [1:0]    act_eff;
    logic          pool_ok;

    dtpm_ram #(.WIDTH(LW), .DEPTH(ENT)) u_child (
        .clk(clk), .we(we), .addr(addr), .wdata(c_wdata), .rdata(c_rdata));
    dtpm_ram #(.WIDTH(VALUE_BITS + 1), .DEPTH(ENT)) u_slot (
        .clk(clk), .we(we), .addr(addr), .wdata(s_wdata), .rdata(s_rdata));

    assign empty = !res_valid_reg;
    assign status = res_status_reg;
    assign match_value = res_value_reg;
    assign nodes_allocated = res_alloc_reg;
    assign pool_ok = (free_reg < LW'(NODES));

    // Registers of the sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtpm_pkg::S_IDLE;
            walk_reg <= '0;
            root_reg <= '0;
            new_reg <= '0;
            root_valid_reg <= 1'b0;
            free_reg <= '0;
            alloc_reg <= '0;
            open_reg <= 1'b0;
            ended_reg <= 1'b0;
            failed_reg <= 1'b0;
            act_reg <= '0;
            best_full_reg <= 1'b0;
            best_reg <= '0;
            clr_reg <= '0;
            link_clr_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            res_status_reg <= '0;
            res_value_reg <= '0;
            res_alloc_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg <= walk_next;
            root_reg <= root_next;
            new_reg <= new_next;
            root_valid_reg <= root_valid_next;
            free_reg <= free_next;
            alloc_reg <= alloc_next;
            open_reg <= open_next;
            ended_reg <= ended_next;
            failed_reg <= failed_next;
            act_reg <= act_next;
            best_full_reg <= best_full_next;
            best_reg <= best_next;
            clr_reg <= clr_next;
            link_clr_reg <= link_clr_next;
            res_valid_reg <= res_valid_next;
            res_status_reg <= res_status_next;
            res_value_reg <= res_value_next;
            res_alloc_reg <= res_alloc_next;
        end
    end

    // Next state: open key, clear a fresh node, read entry, execute, emit.
    always_comb
    begin
        state_next = state_reg;
        walk_next = walk_reg;
        root_next = root_reg;
        new_next = new_reg;
        root_valid_next = root_valid_reg;
        free_next = free_reg;
        alloc_next = alloc_reg;
        open_next = open_reg;
        ended_next = ended_reg;
        failed_next = failed_reg;
        act_next = act_reg;
        best_full_next = best_full_reg;
        best_next = best_reg;
        clr_next = clr_reg;
        link_clr_next = link_clr_reg;
        res_valid_next = res_valid_reg;
        res_status_next = res_status_reg;
        res_value_next = res_value_reg;
        res_alloc_next = res_alloc_reg;
        q_take = 1'b0;
        we = 1'b0;
        addr = AW'(walk_reg * dtpm_pkg::FANOUT + q_digit);
        c_wdata = '0;
        s_wdata = '0;
        act_eff = open_reg ? act_reg : q_action;
        if (pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end
        case (state_reg)
            dtpm_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    if (!open_reg)
                    begin
                        open_next = 1'b1;
                        act_next = q_action;
                        ended_next = 1'b0;
                        failed_next = 1'b0;
                        alloc_next = '0;
                        best_full_next = 1'b0;
                        best_next = '0;
                        walk_next = root_reg;
                        if (q_action == dtpm_pkg::ACT_INSERT && !root_valid_reg)
                        begin
                            if (pool_ok)
                            begin
                                root_next = NW'(free_reg);
                                root_valid_next = 1'b1;
                                walk_next = NW'(free_reg);
                                new_next = NW'(free_reg);
                                free_next = free_reg + 1'b1;
                                alloc_next = 11'd1;
                                clr_next = '0;
                                link_clr_next = 1'b0;
                                state_next = dtpm_pkg::S_CLEAR;
                            end
                            else
                            begin
                                failed_next = 1'b1;
                                state_next = dtpm_pkg::S_READ;
                            end
                        end
                        else
                        begin
                            if (q_action != dtpm_pkg::ACT_INSERT && !root_valid_reg)
                            begin
                                ended_next = 1'b1;
                            end
                            state_next = dtpm_pkg::S_READ;
                        end
                    end
                    else
                    begin
                        state_next = dtpm_pkg::S_READ;
                    end
                end
            end
            dtpm_pkg::S_CLEAR:
            begin
                // Zero the ten entries of a newly taken node. A new root still has its
                // digit to walk; a newly linked child has already consumed it.
                we = 1'b1;
                addr = AW'(new_reg * dtpm_pkg::FANOUT + clr_reg);
                clr_next = clr_reg + 1'b1;
                if (clr_reg == 4'(dtpm_pkg::FANOUT - 1))
                begin
                    state_next = link_clr_reg ? dtpm_pkg::S_OUT : dtpm_pkg::S_READ;
                end
            end
            dtpm_pkg::S_READ:
            begin
                // Address presented; data is valid next cycle.
                state_next = dtpm_pkg::S_EXEC;
            end
            dtpm_pkg::S_EXEC:
            begin
                state_next = dtpm_pkg::S_OUT;
                if (act_eff == dtpm_pkg::ACT_INSERT)
                begin
                    if (!failed_reg)
                    begin
                        if (q_last)
                        begin
                            we = 1'b1;
                            c_wdata = c_rdata;
                            s_wdata = {1'b1, q_value};
                        end
                        else if (c_rdata != '0)
                        begin
                            walk_next = NW'(c_rdata - 1'b1);
                        end
                        else if (pool_ok)
                        begin
                            // Link a fresh node, then clear it.
                            we = 1'b1;
                            c_wdata = free_reg + 1'b1;
                            s_wdata = s_rdata;
                            walk_next = NW'(free_reg);
                            new_next = NW'(free_reg);
                            free_next = free_reg + 1'b1;
                            alloc_next = alloc_reg + 1'b1;
                            clr_next = '0;
                            link_clr_next = 1'b1;
                            state_next = dtpm_pkg::S_CLEAR;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                end
                else if (act_eff != dtpm_pkg::ACT_NONE && !ended_reg)
                begin
                    if (s_rdata[VALUE_BITS])
                    begin
                        best_full_next = 1'b1;
                        best_next = s_rdata[VALUE_BITS-1:0];
                    end
                    else if (act_eff == dtpm_pkg::ACT_EXACT)
                    begin
                        best_full_next = 1'b0;
                    end
                    if (c_rdata == '0)
                    begin
                        if (!q_last)
                        begin
                            ended_next = 1'b1;
                            if (act_eff == dtpm_pkg::ACT_EXACT)
                            begin
                                best_full_next = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        walk_next = NW'(c_rdata - 1'b1);
                    end
                end
            end
            dtpm_pkg::S_OUT:
            begin
                // Retire the digit; the last one waits for a free result slot.
                if (!q_last)
                begin
                    q_take = 1'b1;
                    state_next = dtpm_pkg::S_IDLE;
                end
                else if (!res_valid_reg || pop)
                begin
                    q_take = 1'b1;
                    open_next = 1'b0;
                    res_valid_next = 1'b1;
                    res_status_next = dtpm_pkg::ST_MISS;
                    res_value_next = '0;
                    res_alloc_next = '0;
                    if (act_reg == dtpm_pkg::ACT_INSERT)
                    begin
                        res_status_next = failed_reg ? dtpm_pkg::ST_FULL : dtpm_pkg::ST_OK;
                        res_alloc_next = alloc_reg;
                    end
                    else if (act_reg != dtpm_pkg::ACT_NONE && best_full_reg)
                    begin
                        res_status_next = dtpm_pkg::ST_OK;
                        res_value_next = 32'(best_reg);
                    end
                    state_next = dtpm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dtpm_pkg::S_IDLE;
            end
        endcase
    end

    `DT_ASSERT_IMP(a_take_only_out, clk, rst_n, q_take, state_reg == dtpm_pkg::S_OUT)
    `DT_ASSERT_IMP(a_pool_bound, clk, rst_n, 1'b1, free_reg <= LW'(NODES))
    `DT_ASSERT_NEXT(a_clear_follows, clk, rst_n,
        state_reg == dtpm_pkg::S_EXEC && state_next == dtpm_pkg::S_CLEAR,
        clr_reg == '0)

endmodule

FILE: dv/tb_digit_trie_prefix_match_core.sv
// Self-checking testbench for digit_trie_prefix_match_core: directed keys, random keys
// under three idling mixes, and a pool-exhaustion run, all checked by a trie predictor.
// Depends on dtpm_pkg and the core RTL.
module tb_digit_trie_prefix_match_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL = 1024;
    localparam int MAX_KEY = 32;
    localparam int STALL_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  action;
    logic [3:0]  digit;
    logic        last_digit;
    logic [31:0] value;
    logic        empty;
    logic        pop;
    logic [1:0]  status;
    logic [31:0] match_value;
    logic [10:0] nodes_allocated;

    digit_trie_prefix_match_core #(.NODES(POOL), .VALUE_BITS(32)) u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .action(action),
        .digit(digit), .last_digit(last_digit), .value(value), .empty(empty),
        .pop(pop), .status(status), .match_value(match_value),
        .nodes_allocated(nodes_allocated)
    );

    typedef struct {
        logic [1:0]  status;
        logic [31:0] match_value;
        logic [10:0] nodes_allocated;
    } key_result_t;

    typedef struct {
        logic [3:0] d [MAX_KEY];
        int         len;
    } trie_key_t;

    key_result_t pending_results[$];
    trie_key_t   stored_keys[$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          quiet_cycles = 0;

    // Shadow trie state.
    logic [10:0] child_link [POOL*dtpm_pkg::FANOUT];
    logic        slot_full  [POOL*dtpm_pkg::FANOUT];
    logic [31:0] slot_value [POOL*dtpm_pkg::FANOUT];
    int          root_idx = 0;
    bit          root_ok = 0;
    int          pool_fill = 0;
    int          walk_idx = 0;
    bit          best_full = 0;
    logic [31:0] best_val = '0;
    bit          key_open = 0;
    logic [1:0]  key_act = dtpm_pkg::ACT_INSERT;
    bit          key_ended = 0;
    bit          key_failed = 0;
    int          key_alloc = 0;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Takes the next node from the pool and clears its entries.
    function automatic bit take_node(output int idx);
        if (pool_fill >= POOL)
            return 0;
        idx = pool_fill;
        pool_fill++;
        for (int k = 0; k < dtpm_pkg::FANOUT; k++)
        begin
            child_link[idx*dtpm_pkg::FANOUT + k] = '0;
            slot_full[idx*dtpm_pkg::FANOUT + k] = 1'b0;
            slot_value[idx*dtpm_pkg::FANOUT + k] = '0;
        end
        key_alloc++;
        return 1;
    endfunction

    // Advances the shadow trie by one accepted digit request and queues any key result.
    function automatic void walk_trie(logic [1:0] act, logic [3:0] dig, logic last,
                                      logic [31:0] val);
        int d;
        int pos;
        int link;
        int nn;
        key_result_t res;
        d = dig;
        if (d >= 10)
            d -= 10;
        if (!key_open)
        begin
            key_open = 1;
            key_act = act;
            key_ended = 0;
            key_failed = 0;
            key_alloc = 0;
            best_full = 0;
            best_val = '0;
            if (key_act == dtpm_pkg::ACT_INSERT && !root_ok)
            begin
                if (take_node(nn))
                begin
                    root_idx = nn;
                    root_ok = 1;
                end
                else
                    key_failed = 1;
            end
            if (key_act != dtpm_pkg::ACT_INSERT && !root_ok)
                key_ended = 1;
            walk_idx = root_idx;
        end
        pos = (walk_idx % POOL) * dtpm_pkg::FANOUT + d;
        if (key_act == dtpm_pkg::ACT_INSERT)
        begin
            if (!key_failed)
            begin
                if (last)
                begin
                    slot_full[pos] = 1'b1;
                    slot_value[pos] = val;
                end
                else
                begin
                    link = child_link[pos];
                    if (link == 0)
                    begin
                        if (take_node(nn))
                        begin
                            child_link[pos] = 11'(nn + 1);
                            link = nn + 1;
                        end
                        else
                            key_failed = 1;
                    end
                    if (link != 0)
                        walk_idx = link - 1;
                end
            end
        end
        else if (key_act <= dtpm_pkg::ACT_PREFIX && !key_ended)
        begin
            if (slot_full[pos])
            begin
                best_full = 1;
                best_val = slot_value[pos];
            end
            else if (key_act == dtpm_pkg::ACT_EXACT)
                best_full = 0;
            link = child_link[pos];
            if (link == 0)
            begin
                if (!last)
                begin
                    key_ended = 1;
                    if (key_act == dtpm_pkg::ACT_EXACT)
                        best_full = 0;
                end
            end
            else
                walk_idx = link - 1;
        end
        if (!last)
            return;
        key_open = 0;
        res.status = dtpm_pkg::ST_MISS;
        res.match_value = '0;
        res.nodes_allocated = '0;
        if (key_act == dtpm_pkg::ACT_INSERT)
        begin
            res.status = key_failed ? dtpm_pkg::ST_FULL : dtpm_pkg::ST_OK;
            res.nodes_allocated = 11'(key_alloc);
        end
        else if (key_act <= dtpm_pkg::ACT_PREFIX && best_full)
        begin
            res.status = dtpm_pkg::ST_OK;
            res.match_value = best_val;
        end
        pending_results.push_back(res);
    endfunction

    // Sends one digit request, idling first at the current sender rate.
    task automatic send_digit(logic [1:0] act, logic [3:0] dig, logic last, logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push <= 1'b1;
        action <= act;
        digit <= dig;
        last_digit <= last;
        value <= val;
        do
            @(posedge clk);
        while (full);
        walk_trie(act, dig, last, val);
    endtask

    // Sends a whole key; later digits carry random actions that the core must ignore.
    task automatic send_key(logic [1:0] act, trie_key_t k, logic [31:0] val);
        for (int i = 0; i < k.len; i++)
            send_digit(i == 0 ? act : 2'($urandom_range(3)), k.d[i], i == k.len - 1,
                       i == k.len - 1 ? val : $urandom);
    endtask

    function automatic trie_key_t make_key(int len, int max_digit);
        trie_key_t k;
        k.len = len;
        for (int i = 0; i < MAX_KEY; i++)
            k.d[i] = 4'($urandom_range(max_digit));
        return k;
    endfunction

    // Holds the sender until every expected result has come back.
    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            key_result_t exp_res;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d match_value=%h nodes=%0d",
                         $time, status, match_value, nodes_allocated);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (status !== exp_res.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_res.status, status);
                    error_count++;
                end
                if (match_value !== exp_res.match_value)
                begin
                    $display("%0t: match_value expected %h actual %h",
                             $time, exp_res.match_value, match_value);
                    error_count++;
                end
                if (nodes_allocated !== exp_res.nodes_allocated)
                begin
                    $display("%0t: nodes_allocated expected %0d actual %0d",
                             $time, exp_res.nodes_allocated, nodes_allocated);
                    error_count++;
                end
            end
        end
    end

    // Receiver stalls at the current rate.
    always @(negedge clk)
        pop <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog on cycles with no accepted request or result.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Edge cases: empty trie, action three, value extremes, folded digits, prefixes.
    task automatic test_directed();
        trie_key_t k;
        k = make_key(1, 9);
        k.d[0] = 4'd5;
        send_key(dtpm_pkg::ACT_EXACT, k, '0);
        send_key(dtpm_pkg::ACT_PREFIX, k, '0);
        send_key(dtpm_pkg::ACT_NONE, k, '1);
        send_key(dtpm_pkg::ACT_INSERT, k, 32'hFFFF_FFFF);
        stored_keys.push_back(k);
        k.len = 3;
        k.d[1] = 4'd15;
        k.d[2] = 4'd0;
        send_key(dtpm_pkg::ACT_INSERT, k, 32'h0000_0000);
        stored_keys.push_back(k);
        wait_drained();
        k.d[1] = 4'd5;
        send_key(dtpm_pkg::ACT_EXACT, k, '0);
        k.len = 2;
        send_key(dtpm_pkg::ACT_EXACT, k, '0);
        k.len = 5;
        k.d[3] = 4'd12;
        k.d[4] = 4'd9;
        send_key(dtpm_pkg::ACT_PREFIX, k, '0);
        send_key(dtpm_pkg::ACT_EXACT, k, '0);
        k.d[0] = 4'd10;
        k.d[1] = 4'd9;
        k.d[2] = 4'd14;
        k.len = 3;
        send_key(dtpm_pkg::ACT_INSERT, k, 32'hA5A5_5A5A);
        stored_keys.push_back(k);
        send_key(dtpm_pkg::ACT_NONE, k, '0);
        send_key(dtpm_pkg::ACT_PREFIX, k, '0);
    endtask

    // Mostly well-formed keys drawn from or derived from those already stored.
    task automatic test_random_keys(int n_keys);
        trie_key_t k;
        int pick;
        logic [1:0] act;
        for (int i = 0; i < n_keys; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 65 && stored_keys.size() > 0)
            begin
                k = stored_keys[$urandom_range(stored_keys.size() - 1)];
                if (pick < 20 && k.len > 1)
                    k.len = $urandom_range(1, k.len - 1);
                else if (pick < 40 && k.len < 8)
                    k.len = k.len + $urandom_range(1, 2);
            end
            else
                k = make_key($urandom_range(1, 5), $urandom_range(9) == 0 ? 15 : 9);
            pick = $urandom_range(99);
            act = pick < 40 ? dtpm_pkg::ACT_INSERT :
                  pick < 68 ? dtpm_pkg::ACT_EXACT :
                  pick < 95 ? dtpm_pkg::ACT_PREFIX : dtpm_pkg::ACT_NONE;
            send_key(act, k, $urandom);
            if (act == dtpm_pkg::ACT_INSERT && stored_keys.size() < 200)
                stored_keys.push_back(k);
        end
    endtask

    // Long inserts fill the node pool, then more inserts and searches run on a full pool.
    task automatic test_pool_exhaustion();
        trie_key_t k;
        while (pool_fill < POOL)
        begin
            k = make_key(MAX_KEY, 9);
            send_key(dtpm_pkg::ACT_INSERT, k, $urandom);
        end
        for (int i = 0; i < 3; i++)
            send_key(dtpm_pkg::ACT_INSERT, make_key(4, 9), $urandom);
        test_random_keys(6);
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        action = dtpm_pkg::ACT_INSERT;
        digit = '0;
        last_digit = 1'b0;
        value = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 27;
        recv_idle_pct = 76;
        test_directed();
        test_random_keys(8);
        send_idle_pct = 76;
        recv_idle_pct = 27;
        test_random_keys(8);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_keys(8);
        test_pool_exhaustion();

        @(negedge clk);
        push <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/dtpm_pkg.sv
rtl/core/dtpm_ram.sv
rtl/core/dtpm_front.sv
rtl/core/dtpm_back.sv
rtl/core/digit_trie_prefix_match_core.sv
dv/tb_digit_trie_prefix_match_core.sv
